// File: rtl/icmp_chk_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the ones' complement add for the ICMP echo reply checker.
// No dependencies; imported by every module of the block.

package icmp_chk_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register word index (paddr[APB_ADDR_W-1:2])
    localparam logic [APB_ADDR_W-3:0] REG_EXPECTED_ID = '0;

    localparam logic [5:0]  MIN_HEADER      = 6'd20;
    localparam logic [15:0] MIN_HEADER_LEN  = 16'd20;
    localparam logic [15:0] MIN_ICMP        = 16'd8;
    localparam logic [15:0] BYTE_COUNT_MAX  = 16'hffff;
    localparam logic [15:0] CSUM_GOOD       = 16'hffff;
    localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;

    // byte positions in the IPv4 header and the ICMP part
    localparam logic [15:0] IDX_IHL      = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI  = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO  = 16'd3;
    localparam logic [15:0] IDX_MIN_ICMP = 16'd4;
    localparam logic [15:0] OFF_TYPE     = 16'd0;
    localparam logic [15:0] OFF_ID_HI    = 16'd4;
    localparam logic [15:0] OFF_ID_LO    = 16'd5;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_BAD_CSUM  = 3'd1,
        VERDICT_ID_MISS   = 3'd2,
        VERDICT_NOT_REPLY = 3'd3,
        VERDICT_MALFORMED = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [15:0] icmp_length;
        t_verdict    verdict;
    } t_result;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: rtl/icmp_chk_apb.sv
`timescale 1ns / 1ps
// APB register file: holds the expected echo identifier.
// Depends on icmp_chk_pkg.

module icmp_chk_apb (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [icmp_chk_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [icmp_chk_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [icmp_chk_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                                 o_pready,
    output logic [15:0]                          o_expected_id
);
    import icmp_chk_pkg::*;

    logic        w_hit;
    logic        w_wr;
    logic [15:0] r_expected_id;

    assign w_hit = (i_paddr[APB_ADDR_W-1:2] == REG_EXPECTED_ID);
    assign w_wr  = i_psel && i_penable && i_pwrite && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
        end else if (w_wr) begin
            r_expected_id <= i_pwdata[15:0];
        end
    end

    assign o_prdata      = w_hit ? {{(APB_DATA_W-16){1'b0}}, r_expected_id} : '0;
    assign o_pready      = 1'b1;
    assign o_expected_id = r_expected_id;

endmodule

// File: rtl/icmp_chk_core.sv
`timescale 1ns / 1ps
// Input byte register, per-packet parse/checksum state and verdict logic.
// Depends on icmp_chk_pkg.

module icmp_chk_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    input  logic [15:0]           i_expected_id,
    input  logic                  i_out_free,
    output logic                  o_load,
    output icmp_chk_pkg::t_result o_result
);
    import icmp_chk_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        w_adv;

    // packet state
    logic [15:0] r_byte_count, n_byte_count;
    logic [5:0]  r_header_bytes, n_header_bytes;
    logic [15:0] r_total_length, n_total_length;
    logic [15:0] r_ones_sum, n_ones_sum;
    logic [7:0]  r_pending_high, n_pending_high;
    logic [15:0] r_seen_id, n_seen_id;
    logic [7:0]  r_seen_type, n_seen_type;

    logic [15:0] w_hdr16;
    logic [15:0] w_off;
    logic        w_in_icmp;
    logic [15:0] w_icmp_len;
    logic        w_len_ok;
    logic        w_malformed;
    logic [15:0] w_sum_odd;
    logic [15:0] w_sum_final;
    t_verdict    w_verdict;

    // a last byte waits only for the output slot
    assign w_adv    = r_in_valid && (!r_in_last || i_out_free);
    assign o_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tready) begin
            r_in_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    always_comb begin
        n_header_bytes = r_header_bytes;
        n_total_length = r_total_length;
        n_ones_sum     = r_ones_sum;
        n_pending_high = r_pending_high;
        n_seen_id      = r_seen_id;
        n_seen_type    = r_seen_type;

        if (r_byte_count == IDX_IHL) begin
            n_header_bytes = {r_in_byte[3:0], 2'b00};
        end else if (r_byte_count == IDX_TLEN_HI) begin
            n_total_length = {r_in_byte, r_total_length[7:0]};
        end else if (r_byte_count == IDX_TLEN_LO) begin
            n_total_length = {r_total_length[15:8], r_in_byte};
        end

        w_hdr16   = {10'd0, n_header_bytes};
        w_off     = r_byte_count - w_hdr16;
        w_in_icmp = (n_header_bytes >= MIN_HEADER) && (r_byte_count >= IDX_MIN_ICMP)
                    && (r_byte_count >= w_hdr16) && (r_byte_count < n_total_length);

        if (w_in_icmp) begin
            if (w_off == OFF_TYPE) begin
                n_seen_type = r_in_byte;
            end else if (w_off == OFF_ID_HI) begin
                n_seen_id = {r_in_byte, r_seen_id[7:0]};
            end else if (w_off == OFF_ID_LO) begin
                n_seen_id = {r_seen_id[15:8], r_in_byte};
            end
            if (!w_off[0]) begin
                n_pending_high = r_in_byte;
            end else begin
                n_ones_sum = add_ones(r_ones_sum, {r_pending_high, r_in_byte});
            end
        end

        n_byte_count = (r_byte_count != BYTE_COUNT_MAX) ? r_byte_count + 16'd1
                                                         : r_byte_count;

        // verdict for a packet ending on this byte
        w_len_ok    = (n_total_length >= w_hdr16);
        w_icmp_len  = w_len_ok ? n_total_length - w_hdr16 : 16'd0;
        w_malformed = (n_header_bytes < MIN_HEADER) || (n_byte_count < MIN_HEADER_LEN)
                      || (n_byte_count < n_total_length) || !w_len_ok
                      || (w_icmp_len < MIN_ICMP);
        // odd length: the final ICMP byte never closes a word, so pad from the old sum
        w_sum_odd   = add_ones(r_ones_sum, {n_pending_high, 8'h00});
        w_sum_final = w_icmp_len[0] ? w_sum_odd : n_ones_sum;

        if (w_malformed) begin
            w_verdict = VERDICT_MALFORMED;
        end else if (w_sum_final != CSUM_GOOD) begin
            w_verdict = VERDICT_BAD_CSUM;
        end else if (n_seen_id != i_expected_id) begin
            w_verdict = VERDICT_ID_MISS;
        end else if (n_seen_type != ECHO_REPLY_TYPE) begin
            w_verdict = VERDICT_NOT_REPLY;
        end else begin
            w_verdict = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_header_bytes <= '0;
            r_total_length <= '0;
            r_ones_sum     <= '0;
            r_pending_high <= '0;
            r_seen_id      <= '0;
            r_seen_type    <= '0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_byte_count   <= '0;
                r_header_bytes <= '0;
                r_total_length <= '0;
                r_ones_sum     <= '0;
                r_pending_high <= '0;
                r_seen_id      <= '0;
                r_seen_type    <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_header_bytes <= n_header_bytes;
                r_total_length <= n_total_length;
                r_ones_sum     <= n_ones_sum;
                r_pending_high <= n_pending_high;
                r_seen_id      <= n_seen_id;
                r_seen_type    <= n_seen_type;
            end
        end
    end

    assign o_load               = w_adv && r_in_last;
    assign o_result.verdict     = w_verdict;
    assign o_result.icmp_length = w_icmp_len;

endmodule

// File: rtl/icmp_chk_out.sv
`timescale 1ns / 1ps
// Result register on the master stream side.
// Depends on icmp_chk_pkg.

module icmp_chk_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  icmp_chk_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [23:0]           o_tdata
);
    import icmp_chk_pkg::*;

    logic    r_valid;
    t_result r_result;

    // slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {5'd0, r_result.icmp_length, r_result.verdict};

endmodule

// File: rtl/icmp_echo_reply_checker.sv
`timescale 1ns / 1ps
// Top level of the ICMP echo reply checker: APB register, parse core, result register.
// Depends on icmp_chk_pkg, icmp_chk_apb, icmp_chk_core, icmp_chk_out.

// The checker takes a received IPv4 packet one byte per request on the slave stream,
// header first, with tlast on the final byte. It picks up the header length (IHL x 4)
// from byte 0 and the total length from bytes 2-3, runs an RFC 1071 style 16-bit ones'
// complement sum over the ICMP part (an odd trailing byte is zero padded), and captures
// the ICMP type and identifier. Bytes beyond the total length are ignored. On the last
// byte it issues one result request: verdict 0 accepted, 1 bad checksum, 2 identifier
// differs from the expected_id register (APB offset 0x0, low 16 bits), 3 type is not
// echo reply, 4 malformed (short packet, IHL below 5, total length below header length,
// or fewer than 8 ICMP bytes); it also reports the ICMP length (total minus header, or 0).
// Throughput is one byte per clock, set by the checksum accumulate; bytes keep flowing
// while a verdict waits at the output, and only a further last byte holds until the
// output slot frees. After acceptance the last byte passes the input byte register and
// then the result register before the result appears on the master stream. Write
// expected_id only while no packet is in flight.

module icmp_echo_reply_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
    input  logic                                 s_axis_tlast,  // last
    // master stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [23:0]                          m_axis_tdata,  // [2:0] verdict,
                                                                // [18:3] icmp_length,
                                                                // [23:19] zero
    // APB
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [icmp_chk_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [icmp_chk_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [icmp_chk_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import icmp_chk_pkg::*;

    logic [15:0] w_expected_id;
    logic        w_out_free;
    logic        w_load;
    t_result     w_result;

    icmp_chk_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_prdata      (prdata),
        .o_pready      (pready),
        .o_expected_id (w_expected_id)
    );

    // byte register + parse/checksum state; verdict computed as the last byte retires
    icmp_chk_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_data_byte   (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_expected_id (w_expected_id),
        .i_out_free    (w_out_free),
        .o_load        (w_load),
        .o_result      (w_result)
    );

    // holds one verdict until the master side takes it
    icmp_chk_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

// File: tb/icmp_verdict_monitor.sv
`timescale 1ns / 1ps
// Checker for the ICMP echo reply checker: tracks the byte stream and register writes,
// predicts every verdict, and compares it with the master stream. Depends on icmp_chk_pkg.

module icmp_verdict_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_in_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [23:0]                         i_out_data,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [icmp_chk_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [icmp_chk_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import icmp_chk_pkg::*;

    // per-packet parse state of the predictor
    logic [15:0] pkt_count;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [15:0] csum_acc;
    logic [7:0]  hi_byte;
    logic [15:0] got_id;
    logic [7:0]  got_type;
    logic [15:0] cfg_id;

    t_result verdict_queue[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] s;
        s = {16'd0, a} + {16'd0, b};
        return s[15:0] + s[31:16];
    endfunction

    function automatic void clear_packet();
        pkt_count = '0;
        hdr_len   = '0;
        tot_len   = '0;
        csum_acc  = '0;
        hi_byte   = '0;
        got_id    = '0;
        got_type  = '0;
    endfunction

    // Advance the parse by one byte; returns 1 with the verdict on the last byte.
    function automatic bit predict_verdict(input logic [7:0] b, input logic l,
                                           output t_result res);
        logic [15:0] pos;
        logic [15:0] off;
        logic [15:0] ilen;
        logic [15:0] s;
        pos = pkt_count;
        res = '0;
        if (pos == IDX_IHL) begin
            hdr_len = {b[3:0], 2'b00};
        end else if (pos == IDX_TLEN_HI) begin
            tot_len[15:8] = b;
        end else if (pos == IDX_TLEN_LO) begin
            tot_len[7:0] = b;
        end
        // only bytes inside the ICMP part are summed; trailing bytes fall out here
        if (hdr_len >= MIN_HEADER && pos >= IDX_MIN_ICMP && pos >= {10'd0, hdr_len}
                && pos < tot_len) begin
            off = pos - {10'd0, hdr_len};
            if (off == OFF_TYPE) begin
                got_type = b;
            end else if (off == OFF_ID_HI) begin
                got_id[15:8] = b;
            end else if (off == OFF_ID_LO) begin
                got_id[7:0] = b;
            end
            if (!off[0]) begin
                hi_byte = b;
            end else begin
                csum_acc = fold_add(csum_acc, {hi_byte, b});
            end
        end
        if (pkt_count != BYTE_COUNT_MAX) begin
            pkt_count = pkt_count + 16'd1;
        end
        if (!l) begin
            return 1'b0;
        end
        ilen = (tot_len >= {10'd0, hdr_len}) ? tot_len - {10'd0, hdr_len} : 16'd0;
        res.icmp_length = ilen;
        if (hdr_len < MIN_HEADER || pkt_count < MIN_HEADER_LEN || pkt_count < tot_len
                || tot_len < {10'd0, hdr_len} || ilen < MIN_ICMP) begin
            res.verdict = VERDICT_MALFORMED;
        end else begin
            s = csum_acc;
            if (ilen[0]) begin
                s = fold_add(s, {hi_byte, 8'h00});   // odd trailing byte, zero padded
            end
            if (s != CSUM_GOOD) begin
                res.verdict = VERDICT_BAD_CSUM;
            end else if (got_id != cfg_id) begin
                res.verdict = VERDICT_ID_MISS;
            end else if (got_type != ECHO_REPLY_TYPE) begin
                res.verdict = VERDICT_NOT_REPLY;
            end else begin
                res.verdict = VERDICT_ACCEPT;
            end
        end
        clear_packet();
        return 1'b1;
    endfunction

    task automatic note_failure(input string what, input t_result want, input logic [23:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] %s: verdict exp %0d got %0d, icmp_length exp %0d got %0d, pad %h",
                     $time, what, want.verdict, got[2:0], want.icmp_length, got[18:3],
                     got[23:19]);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            cfg_id = '0;
            clear_packet();
            verdict_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_ADDR_W-1:2] == REG_EXPECTED_ID) begin
                cfg_id = i_pwdata[15:0];
            end
            // compare first: a verdict cannot leave in the cycle its last byte enters
            if (i_out_valid && i_out_ready) begin
                if (verdict_queue.size() == 0) begin
                    note_failure("result with nothing pending", '0, i_out_data);
                end else begin
                    want = verdict_queue.pop_front();
                    o_checked++;
                    if (i_out_data[2:0] != want.verdict
                            || i_out_data[18:3] != want.icmp_length
                            || i_out_data[23:19] != 5'd0) begin
                        note_failure("verdict mismatch", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (predict_verdict(i_in_byte, i_in_last, fresh)) begin
                    verdict_queue.push_back(fresh);
                end
            end
        end
        o_pending = verdict_queue.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the ICMP echo reply checker testbench: clock, reset, stimulus and verdict.
// Depends on icmp_chk_pkg, icmp_echo_reply_checker and icmp_verdict_monitor.

module testbench;
    import icmp_chk_pkg::*;

    localparam int BYTE_TARGET = 1950;
    localparam int PHASES      = 6;
    localparam int DRAIN_LIMIT = 5000;

    localparam logic [APB_ADDR_W-1:0] ADDR_EXPECTED_ID = {REG_EXPECTED_ID, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = 3'd4;   // no register there

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;    // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [2:0] verdict, [18:3] icmp_length, [23:19] zero

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;

    bit          no_idle    = 1'b0;   // stretches with back-to-back traffic on both sides
    int          rx_stall   = 0;
    logic [15:0] cur_id     = 16'h0000;
    logic [7:0]  pkt_bytes[$];
    int          pkt_total  = 0;
    int          byte_total = 0;
    int          id_writes  = 0;

    icmp_echo_reply_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    icmp_verdict_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case a request or a verdict never arrives.
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result side backpressure.
    always @(posedge i_clk) begin
        if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall = gap_len();
            m_axis_tready <= (rx_stall == 0);
            if (rx_stall != 0) begin
                rx_stall = rx_stall - 1;
            end
        end
    end

    // One byte request; tvalid stays up when the next byte follows without a gap.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[k]) begin
            send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
        end
        pkt_total++;
        byte_total += pkt_bytes.size();
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_expected_id(input logic [15:0] id);
        logic [31:0] word;
        word = $urandom();          // upper bits are don't-care for the register
        word[15:0] = id;
        apb_write(ADDR_EXPECTED_ID, word);
        cur_id = id;
        id_writes++;
    endtask

    // Stop sending and let every pending verdict come out, then idle
    // so nothing is still in the two-stage output path.
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_tot_len(input logic [15:0] v);
        pkt_bytes[2] = v[15:8];
        pkt_bytes[3] = v[7:0];
    endtask

    // Build an IPv4 packet carrying an ICMP message, with a correct checksum if it has 4 or more ICMP bytes.
    // ihl must be 5 or more; trailing bytes past the total length are appended.
    task automatic build_reply(input logic [3:0] ihl, input int icmp_bytes,
                               input logic [15:0] id, input logic [7:0] kind,
                               input int extra);
        int          hdr;
        logic [15:0] tot;
        logic [31:0] acc;
        logic [15:0] csum;
        logic [7:0]  lo;
        hdr = ihl * 4;
        tot = 16'(hdr + icmp_bytes);
        pkt_bytes.delete();
        for (int k = 0; k < hdr; k++) begin
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        pkt_bytes[0] = {4'h4, ihl};
        set_tot_len(tot);
        for (int k = 0; k < icmp_bytes; k++) begin
            case (k)
                0:       pkt_bytes.push_back(kind);
                2, 3:    pkt_bytes.push_back(8'h00);
                4:       pkt_bytes.push_back(id[15:8]);
                5:       pkt_bytes.push_back(id[7:0]);
                default: pkt_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        acc = '0;
        for (int k = 0; k < icmp_bytes; k += 2) begin
            lo  = (k + 1 < icmp_bytes) ? pkt_bytes[hdr + k + 1] : 8'h00;
            acc = acc + {16'd0, pkt_bytes[hdr + k], lo};
        end
        acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        csum = ~acc[15:0];
        if (icmp_bytes >= 4) begin
            pkt_bytes[hdr + 2] = csum[15:8];
            pkt_bytes[hdr + 3] = csum[7:0];
        end
        repeat (extra) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int          r;
        int          ilen;
        int          extra;
        int          phase_bytes;
        int          phase_quota;
        int          cut;
        int          idx;
        logic [3:0]  ihl;
        logic [15:0] id;
        logic [7:0]  kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed packets ----
        // expected_id still at its reset value of zero
        build_reply(4'd5, 8, 16'h0000, ECHO_REPLY_TYPE, 0);
        send_packet();
        // a write to the unused word must leave expected_id alone
        wait_drained();
        apb_write(ADDR_SPARE, 32'h0000_1234);
        build_reply(4'd5, 8, 16'h0000, ECHO_REPLY_TYPE, 0);
        send_packet();

        wait_drained();
        set_expected_id(16'hffff);
        // longest header with an odd ICMP length (zero pad on the last word)
        build_reply(4'd15, 9, 16'hffff, ECHO_REPLY_TYPE, 0);
        send_packet();
        // identifier off by one
        build_reply(4'd5, 8, 16'hfffe, ECHO_REPLY_TYPE, 0);
        send_packet();
        // echo request instead of reply
        build_reply(4'd5, 12, 16'hffff, 8'd8, 0);
        send_packet();
        // type at its max, with trailing bytes past the total length
        build_reply(4'd5, 8, 16'hffff, 8'hff, 3);
        send_packet();
        // one bit flipped in the low byte of the identifier
        build_reply(4'd5, 16, 16'hffff, ECHO_REPLY_TYPE, 0);
        pkt_bytes[25] = pkt_bytes[25] ^ 8'h80;
        send_packet();
        // all-zero ICMP part: a zero sum is a bad checksum
        build_reply(4'd5, 8, 16'h0000, ECHO_REPLY_TYPE, 0);
        for (int k = 20; k < 28; k++) begin
            pkt_bytes[k] = 8'h00;
        end
        send_packet();
        // IHL of zero and IHL of four
        build_reply(4'd5, 8, 16'hffff, ECHO_REPLY_TYPE, 0);
        pkt_bytes[0] = 8'h40;
        send_packet();
        build_reply(4'd5, 8, 16'hffff, ECHO_REPLY_TYPE, 0);
        pkt_bytes[0] = 8'h44;
        send_packet();
        // total length below the header length
        build_reply(4'd6, 8, 16'hffff, ECHO_REPLY_TYPE, 0);
        set_tot_len(16'd10);
        send_packet();
        // ICMP part shorter than the 8-byte minimum
        build_reply(4'd5, 7, 16'hffff, ECHO_REPLY_TYPE, 0);
        send_packet();
        build_reply(4'd5, 0, 16'hffff, ECHO_REPLY_TYPE, 0);
        send_packet();
        // packet ends one byte early
        build_reply(4'd5, 20, 16'hffff, ECHO_REPLY_TYPE, 0);
        void'(pkt_bytes.pop_back());
        send_packet();
        // total length at its max on a short packet
        build_reply(4'd5, 8, 16'hffff, ECHO_REPLY_TYPE, 0);
        set_tot_len(16'hffff);
        send_packet();
        // fewer than 20 bytes in all
        build_reply(4'd5, 8, 16'hffff, ECHO_REPLY_TYPE, 0);
        while (pkt_bytes.size() > 19) void'(pkt_bytes.pop_back());
        send_packet();
        // last on the very first byte
        pkt_bytes = '{8'hff};
        send_packet();

        wait_drained();
        set_expected_id(16'h0000);
        build_reply(4'd5, 8, 16'h0000, ECHO_REPLY_TYPE, 0);
        send_packet();

        // ---- random packets, a new expected_id per phase ----
        // the remaining byte budget is split evenly over the phases
        phase_quota = (BYTE_TARGET - byte_total) / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            // sender holds off until every verdict is out, then the register moves
            wait_drained();
            if (p == 0) begin
                set_expected_id(16'hffff);
            end else if (p == 1) begin
                set_expected_id(16'h0000);
            end else begin
                set_expected_id(16'($urandom_range(0, 65535)));
            end
            no_idle = (p == 3);
            phase_bytes = 0;
            while (phase_bytes < phase_quota) begin
                r     = $urandom_range(0, 99);
                ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
                ilen  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 200)
                                                    : $urandom_range(8, 40);
                id    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : cur_id;
                kind  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                    : ECHO_REPLY_TYPE;
                extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
                build_reply(ihl, ilen, id, kind, extra);
                if (r < 60) begin
                    // well formed, random content
                end else if (r < 72) begin
                    idx = ihl * 4 + $urandom_range(0, ilen - 1);
                    pkt_bytes[idx] = pkt_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
                end else if (r < 78) begin
                    cut = $urandom_range(1, ilen);
                    repeat (cut + extra) void'(pkt_bytes.pop_back());
                end else if (r < 83) begin
                    pkt_bytes[0][3:0] = 4'($urandom_range(0, 4));
                end else if (r < 88) begin
                    set_tot_len(16'($urandom_range(0, ihl * 4 - 1)));
                end else if (r < 93) begin
                    build_reply(ihl, $urandom_range(0, 7), id, kind, extra);
                end else begin
                    pkt_bytes.delete();
                    repeat ($urandom_range(1, 48))
                        pkt_bytes.push_back(8'($urandom_range(0, 255)));
                end
                phase_bytes += pkt_bytes.size();
                send_packet();
            end
        end

        wait_drained();
        @(negedge i_clk);
        $display("Sent %0d packets (%0d bytes) over %0d id settings, with stalls both sides.",
                 pkt_total, byte_total, id_writes);
        $display("Checked %0d verdicts, %0d mismatches, %0d still pending.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
